@@ rtl/core/token_lcs_with_traceback_assert.svh @@
// Assertion macros for the token LCS block.
// Used by the top level; needs no package.
`ifndef TOKEN_LCS_WITH_TRACEBACK_ASSERT_SVH
`define TOKEN_LCS_WITH_TRACEBACK_ASSERT_SVH

// property that holds on every clock edge outside reset
`define LCS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define LCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lcs_pkg.sv @@
// Shared types for the token LCS block: sequencer states, traceback
// directions and token store control. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ROW,
      ST_RD,
      ST_CALC,
      ST_TB_CHK,
      ST_TB_STEP,
      ST_POP,
      ST_WRD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIR_LEFT = 2'd1,
      DIR_UP   = 2'd2,
      DIR_DIAG = 2'd3
   } dir_type;

   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic rd_first;
      logic rd_second;
   } tok_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/lcs_cell.sv @@
// Shared table cell unit: token compare, diagonal increment and up/left pick.
// Depends on lcs_pkg for the direction codes.
`timescale 1ns / 1ps
`default_nettype none

module lcs_cell
   import lcs_pkg::*;
#(
   parameter int TOKEN_BITS = 64,
   parameter int SCORE_W    = 7
) (
   input  wire logic [TOKEN_BITS-1:0] tok_a,
   input  wire logic [TOKEN_BITS-1:0] tok_b,
   input  wire logic [SCORE_W-1:0]    up,
   input  wire logic [SCORE_W-1:0]    left,
   input  wire logic [SCORE_W-1:0]    diag,
   output logic      [SCORE_W-1:0]    score,
   output dir_type                    dir
);

   always_comb begin
      priority if (tok_a == tok_b) begin
         score = diag + SCORE_W'(1);
         dir   = DIR_DIAG;
      end else if (up > left) begin
         score = up;
         dir   = DIR_UP;
      end else begin
         score = left;
         dir   = DIR_LEFT;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lcs_tok_store.sv @@
// Token stores for both sequences, one write port and one registered read
// port each. Depends on lcs_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module lcs_tok_store
   import lcs_pkg::*;
#(
   parameter int  MAX_WORDS  = 64,
   parameter int  TOKEN_BITS = 64,
   localparam int IW         = $clog2(MAX_WORDS)
) (
   input  wire logic                  clock,
   input  wire tok_ctl_type           ctl,
   input  wire logic [IW-1:0]         wr_addr,
   input  wire logic [TOKEN_BITS-1:0] wr_data,
   input  wire logic [IW-1:0]         rd_first_addr,
   input  wire logic [IW-1:0]         rd_second_addr,
   output logic      [TOKEN_BITS-1:0] rd_first_data,
   output logic      [TOKEN_BITS-1:0] rd_second_data
);

   logic [TOKEN_BITS-1:0] first_store_ff  [MAX_WORDS];
   logic [TOKEN_BITS-1:0] second_store_ff [MAX_WORDS];
   logic [TOKEN_BITS-1:0] first_q_ff;
   logic [TOKEN_BITS-1:0] second_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_first) begin
         first_store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_first) begin
         first_q_ff <= first_store_ff[rd_first_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_second) begin
         second_store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_second) begin
         second_q_ff <= second_store_ff[rd_second_addr];
      end
   end

   assign rd_first_data  = first_q_ff;
   assign rd_second_data = second_q_ff;

endmodule

`default_nettype wire

@@ rtl/core/token_lcs_with_traceback.sv @@
// Channel | ports                                   | transfer when
// --------+-----------------------------------------+--------------------------
// req     | req_valid req_func req_word_token       | req_valid && !req_stall
// rsp     | rsp_valid rsp_common_word rsp_last_word | rsp_valid && !rsp_stall
//         | rsp_empty_answer rsp_overflow_seen      |
// A word or the first marker is taken in ST_LOAD. The second marker starts the
// fill: each table cell (n1 * n2 cells) passes ST_RD and ST_CALC on the one
// compare/max cell unit and the single-port row score buffer, each row opening
// in ST_ROW; then traceback (at most n1 + n2 steps), then results, held by rsp stall.
// req_stall is high from the second marker until the last result transfers.
// Synchronous reset clears control state only; no clearing pass is needed.
// Depends on lcs_pkg, lcs_cell, lcs_tok_store and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module token_lcs_with_traceback
   import lcs_pkg::*;
#(
   parameter int MAX_WORDS  = 64,
   parameter int TOKEN_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [TOKEN_BITS-1:0] req_word_token,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [TOKEN_BITS-1:0] rsp_common_word,
   output logic                       rsp_last_word,
   output logic                       rsp_empty_answer,
   output logic                       rsp_overflow_seen
);

`include "token_lcs_with_traceback_assert.svh"

   localparam int IW        = $clog2(MAX_WORDS);
   localparam int CW        = $clog2(MAX_WORDS + 1);
   localparam int DIR_AW    = 2 * IW;
   localparam int DIR_DEPTH = 1 << DIR_AW;

   state_type state_ff, state_in;
   logic          which_seq_ff, which_seq_in;
   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic          empty_ff, empty_in;

   logic [CW-1:0] row_score_ff [MAX_WORDS + 1];
   dir_type       dir_store_ff [DIR_DEPTH];
   logic [IW-1:0] stack_store_ff [MAX_WORDS];
   logic [CW-1:0] row_score_q_ff;
   dir_type       dir_q_ff;
   logic [IW-1:0] stack_q_ff;

   tok_ctl_type           tok_ctl;
   logic [IW-1:0]         tok_wr_addr;
   logic [IW-1:0]         tok_rd_first_addr;
   logic [IW-1:0]         tok_rd_second_addr;
   logic [TOKEN_BITS-1:0] first_q;
   logic [TOKEN_BITS-1:0] second_q;

   logic          score_rd, score_wr;
   logic          dir_rd, dir_wr;
   logic          stack_rd, stack_wr;
   logic [DIR_AW-1:0] dir_addr;
   logic [IW-1:0] stack_addr;
   logic [CW-1:0] up_score;
   logic [CW-1:0] cell_score;
   dir_type       cell_dir;
   logic [CW-1:0] row_m1, col_m1, depth_m1;
   logic          last_result;

   lcs_tok_store #(
      .MAX_WORDS  (MAX_WORDS),
      .TOKEN_BITS (TOKEN_BITS)
   ) u_tok_store (
      .clock          (clock),
      .ctl            (tok_ctl),
      .wr_addr        (tok_wr_addr),
      .wr_data        (req_word_token),
      .rd_first_addr  (tok_rd_first_addr),
      .rd_second_addr (tok_rd_second_addr),
      .rd_first_data  (first_q),
      .rd_second_data (second_q)
   );

   lcs_cell #(
      .TOKEN_BITS (TOKEN_BITS),
      .SCORE_W    (CW)
   ) u_cell (
      .tok_a (first_q),
      .tok_b (second_q),
      .up    (up_score),
      .left  (left_ff),
      .diag  (diag_ff),
      .score (cell_score),
      .dir   (cell_dir)
   );

   assign row_m1      = row_ff - CW'(1);
   assign col_m1      = col_ff - CW'(1);
   assign depth_m1    = depth_ff - CW'(1);
   assign up_score    = (row_ff == CW'(1)) ? '0 : row_score_q_ff;
   assign dir_addr    = {row_m1[IW-1:0], col_m1[IW-1:0]};
   assign last_result = empty_ff || (depth_ff == '0);

   always_comb begin
      state_in           = state_ff;
      which_seq_in       = which_seq_ff;
      first_count_in     = first_count_ff;
      second_count_in    = second_count_ff;
      dropped_in         = dropped_ff;
      row_in             = row_ff;
      col_in             = col_ff;
      left_in            = left_ff;
      diag_in            = diag_ff;
      depth_in           = depth_ff;
      empty_in           = empty_ff;
      tok_ctl            = '0;
      tok_wr_addr        = first_count_ff[IW-1:0];
      tok_rd_first_addr  = row_m1[IW-1:0];
      tok_rd_second_addr = col_m1[IW-1:0];
      score_rd           = 1'b0;
      score_wr           = 1'b0;
      dir_rd             = 1'b0;
      dir_wr             = 1'b0;
      stack_rd           = 1'b0;
      stack_wr           = 1'b0;
      stack_addr         = depth_ff[IW-1:0];
      req_stall          = 1'b1;
      rsp_valid          = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!req_func) begin
                  if (!which_seq_ff) begin
                     if (first_count_ff < CW'(MAX_WORDS)) begin
                        tok_ctl.wr_first = 1'b1;
                        first_count_in   = first_count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end else begin
                     tok_wr_addr = second_count_ff[IW-1:0];
                     if (second_count_ff < CW'(MAX_WORDS)) begin
                        tok_ctl.wr_second = 1'b1;
                        second_count_in   = second_count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end else if (!which_seq_ff) begin
                  which_seq_in = 1'b1;
               end else begin
                  depth_in = '0;
                  if ((first_count_ff == '0) || (second_count_ff == '0)) begin
                     row_in   = first_count_ff;
                     col_in   = second_count_ff;
                     state_in = ST_TB_CHK;
                  end else begin
                     row_in   = CW'(1);
                     state_in = ST_ROW;
                  end
               end
            end
         end
         ST_ROW: begin
            tok_ctl.rd_first = 1'b1;
            col_in           = CW'(1);
            left_in          = '0;
            diag_in          = '0;
            state_in         = ST_RD;
         end
         ST_RD: begin
            tok_ctl.rd_second = 1'b1;
            score_rd          = 1'b1;
            state_in          = ST_CALC;
         end
         ST_CALC: begin
            score_wr = 1'b1;
            dir_wr   = 1'b1;
            left_in  = cell_score;
            diag_in  = up_score;
            if (col_ff == second_count_ff) begin
               if (row_ff == first_count_ff) begin
                  state_in = ST_TB_CHK;
               end else begin
                  row_in   = row_ff + CW'(1);
                  state_in = ST_ROW;
               end
            end else begin
               col_in   = col_ff + CW'(1);
               state_in = ST_RD;
            end
         end
         ST_TB_CHK: begin
            if ((row_ff == '0) || (col_ff == '0)) begin
               empty_in = (depth_ff == '0);
               state_in = (depth_ff == '0) ? ST_OUT : ST_POP;
            end else begin
               dir_rd   = 1'b1;
               state_in = ST_TB_STEP;
            end
         end
         ST_TB_STEP: begin
            priority if (dir_q_ff == DIR_LEFT) begin
               col_in = col_m1;
            end else if (dir_q_ff == DIR_UP) begin
               row_in = row_m1;
            end else begin
               row_in   = row_m1;
               col_in   = col_m1;
               stack_wr = 1'b1;
               depth_in = depth_ff + CW'(1);
            end
            state_in = ST_TB_CHK;
         end
         ST_POP: begin
            stack_rd   = 1'b1;
            stack_addr = depth_m1[IW-1:0];
            depth_in   = depth_m1;
            state_in   = ST_WRD;
         end
         ST_WRD: begin
            tok_ctl.rd_first  = 1'b1;
            tok_rd_first_addr = stack_q_ff;
            state_in          = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (last_result) begin
                  which_seq_in    = 1'b0;
                  first_count_in  = '0;
                  second_count_in = '0;
                  dropped_in      = 1'b0;
                  empty_in        = 1'b0;
                  state_in        = ST_LOAD;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         which_seq_ff    <= 1'b0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         depth_ff        <= '0;
         empty_ff        <= 1'b0;
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         which_seq_ff    <= which_seq_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         depth_ff        <= depth_in;
         empty_ff        <= empty_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

   always_ff @(posedge clock) begin
      if (score_wr) begin
         row_score_ff[col_ff] <= cell_score;
      end
      if (score_rd) begin
         row_score_q_ff <= row_score_ff[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dir_wr) begin
         dir_store_ff[dir_addr] <= cell_dir;
      end
      if (dir_rd) begin
         dir_q_ff <= dir_store_ff[dir_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_wr) begin
         stack_store_ff[stack_addr] <= row_m1[IW-1:0];
      end
      if (stack_rd) begin
         stack_q_ff <= stack_store_ff[stack_addr];
      end
   end

   assign rsp_common_word   = empty_ff ? '0 : first_q;
   assign rsp_last_word     = last_result;
   assign rsp_empty_answer  = empty_ff;
   assign rsp_overflow_seen = dropped_ff;

   `LCS_ASSERT_ALWAYS(a_no_rsp_while_loading, clock, reset, !(rsp_valid && !req_stall), "result shown while loading")
   `LCS_ASSERT_IMPL(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_answer, rsp_last_word, "empty answer not marked last")
   `LCS_ASSERT_NEXT(a_clear_after_last, clock, reset, rsp_valid && !rsp_stall && rsp_last_word, !req_stall && (first_count_ff == '0) && !which_seq_ff, "answer end did not clear load state")
   `LCS_ASSERT_ALWAYS(a_depth_bound, clock, reset, depth_ff <= first_count_ff, "traceback depth exceeds first sequence")

endmodule

`default_nettype wire
